/* rtl/gdc_pkg.sv */
// gdc_pkg: shared widths, types, register indexes and the distance-ordered offset table
// for the grid disc cell lister. No dependencies.
package gdc_pkg;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned GRID_SIZE_W = 9;
  localparam int unsigned INDEX_W     = 16;
  localparam int unsigned DIAMETER_W  = 4;
  localparam int unsigned DIST_W      = 5;
  localparam int unsigned COORD_W     = 8;
  localparam int unsigned RADIUS_W    = 3;
  localparam int unsigned STEP_W      = 6;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [GRID_SIZE_W-1:0] MAX_COLUMNS  = 9'd256;
  localparam logic [GRID_SIZE_W-1:0] MAX_ROWS     = 9'd256;
  localparam logic [DIAMETER_W-1:0]  MAX_DIAMETER = 4'd9;

  localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RESET = 9'd16;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t REG_GRID_COLUMNS = 8'd0;
  localparam cfg_index_t REG_GRID_ROWS    = 8'd1;

  typedef struct packed {
    logic [INDEX_W-1:0]  center_index;
    logic [COORD_W-1:0]  center_column;
    logic [INDEX_W-1:0]  center_row;
    logic [RADIUS_W-1:0] radius;
  } job_t;

  typedef struct packed {
    logic signed [3:0]   dx;
    logic signed [3:0]   dz;
    logic [DIST_W-1:0]   dist_sq;
  } offset_t;

  function automatic logic [GRID_SIZE_W-1:0] clamp_size(input logic [GRID_SIZE_W-1:0] v,
                                                       input logic [GRID_SIZE_W-1:0] top);
    logic [GRID_SIZE_W-1:0] res;
    if (v == '0) begin
      res = 9'd1;
    end else if (v > top) begin
      res = top;
    end else begin
      res = v;
    end
    return res;
  endfunction

  function automatic offset_t mk_offset(input int dz, input int dx);
    offset_t e;
    e.dx      = 4'(dx);
    e.dz      = 4'(dz);
    e.dist_sq = 5'(dz * dz + dx * dx);
    return e;
  endfunction

  // offsets ordered by squared distance, then row, then column
  function automatic offset_t offset_entry(input logic [STEP_W-1:0] step);
    offset_t e;
    e = '0;
    unique case (step)
      6'd0:  e = mk_offset( 0,  0);
      6'd1:  e = mk_offset(-1,  0);
      6'd2:  e = mk_offset( 0, -1);
      6'd3:  e = mk_offset( 0,  1);
      6'd4:  e = mk_offset( 1,  0);
      6'd5:  e = mk_offset(-1, -1);
      6'd6:  e = mk_offset(-1,  1);
      6'd7:  e = mk_offset( 1, -1);
      6'd8:  e = mk_offset( 1,  1);
      6'd9:  e = mk_offset(-2,  0);
      6'd10: e = mk_offset( 0, -2);
      6'd11: e = mk_offset( 0,  2);
      6'd12: e = mk_offset( 2,  0);
      6'd13: e = mk_offset(-2, -1);
      6'd14: e = mk_offset(-2,  1);
      6'd15: e = mk_offset(-1, -2);
      6'd16: e = mk_offset(-1,  2);
      6'd17: e = mk_offset( 1, -2);
      6'd18: e = mk_offset( 1,  2);
      6'd19: e = mk_offset( 2, -1);
      6'd20: e = mk_offset( 2,  1);
      6'd21: e = mk_offset(-2, -2);
      6'd22: e = mk_offset(-2,  2);
      6'd23: e = mk_offset( 2, -2);
      6'd24: e = mk_offset( 2,  2);
      6'd25: e = mk_offset(-3,  0);
      6'd26: e = mk_offset( 0, -3);
      6'd27: e = mk_offset( 0,  3);
      6'd28: e = mk_offset( 3,  0);
      6'd29: e = mk_offset(-3, -1);
      6'd30: e = mk_offset(-3,  1);
      6'd31: e = mk_offset(-1, -3);
      6'd32: e = mk_offset(-1,  3);
      6'd33: e = mk_offset( 1, -3);
      6'd34: e = mk_offset( 1,  3);
      6'd35: e = mk_offset( 3, -1);
      6'd36: e = mk_offset( 3,  1);
      6'd37: e = mk_offset(-3, -2);
      6'd38: e = mk_offset(-3,  2);
      6'd39: e = mk_offset(-2, -3);
      6'd40: e = mk_offset(-2,  3);
      6'd41: e = mk_offset( 2, -3);
      6'd42: e = mk_offset( 2,  3);
      6'd43: e = mk_offset( 3, -2);
      6'd44: e = mk_offset( 3,  2);
      6'd45: e = mk_offset(-4,  0);
      6'd46: e = mk_offset( 0, -4);
      6'd47: e = mk_offset( 0,  4);
      6'd48: e = mk_offset( 4,  0);
      default: begin
        // past the table: distance beyond any radius ends the walk
        e.dist_sq = '1;
      end
    endcase
    return e;
  endfunction

endpackage

/* rtl/gdc_intf.sv */
// gdc_intf: valid/ready channel interfaces for requests, results and configuration writes.
// Depends on gdc_pkg for field widths.
interface gdc_req_if;
  logic                               valid;
  logic                               ready;
  logic [gdc_pkg::INDEX_W-1:0]        center_index;
  logic [gdc_pkg::DIAMETER_W-1:0]     diameter;

  modport source (output valid, output center_index, output diameter, input ready);
  modport sink   (input valid, input center_index, input diameter, output ready);
endinterface

interface gdc_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [gdc_pkg::INDEX_W-1:0]        cell_index;
  logic [gdc_pkg::DIST_W-1:0]         distance_sq;
  logic                               last_flag;

  modport source (output valid, output cell_index, output distance_sq, output last_flag,
                  input ready);
  modport sink   (input valid, input cell_index, input distance_sq, input last_flag,
                  output ready);
endinterface

interface gdc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [gdc_pkg::CFG_INDEX_W-1:0]    index;
  logic [gdc_pkg::GRID_SIZE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/gdc_front.sv */
// gdc_front: accepts requests, drops zero diameters, splits the centre index into
// column and row with a bit-serial divider and pushes the job. Depends on gdc_pkg, gdc_intf.
module gdc_front (
  input  logic                               clk,
  input  logic                               rst,
  gdc_req_if.sink                            req,
  input  logic [gdc_pkg::GRID_SIZE_W-1:0]    cols,
  input  logic                               full,
  output logic                               push,
  output gdc_pkg::job_t                      job
);

  localparam int unsigned DIV_COUNT_W = $clog2(gdc_pkg::INDEX_W);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t                        state;
  logic [gdc_pkg::INDEX_W-1:0]         idx;
  logic [gdc_pkg::INDEX_W-1:0]         quot;
  logic [gdc_pkg::COORD_W-1:0]         rem;
  logic [gdc_pkg::RADIUS_W-1:0]        radius;
  logic [DIV_COUNT_W-1:0]              count;

  logic                                accept;
  logic [gdc_pkg::COORD_W:0]           shifted;
  logic                                ge;
  logic [gdc_pkg::COORD_W-1:0]         rem_next;
  logic [gdc_pkg::INDEX_W-1:0]         quot_next;
  logic [gdc_pkg::DIAMETER_W-1:0]      dia_clamped;

  assign req.ready = (state == F_IDLE);
  assign accept    = req.valid && req.ready;

  assign dia_clamped = (req.diameter > gdc_pkg::MAX_DIAMETER) ? gdc_pkg::MAX_DIAMETER
                                                               : req.diameter;

  // one quotient bit per cycle
  assign shifted   = {rem, quot[gdc_pkg::INDEX_W-1]};
  assign ge        = (shifted >= cols);
  assign rem_next  = ge ? gdc_pkg::COORD_W'(shifted - cols) : shifted[gdc_pkg::COORD_W-1:0];
  assign quot_next = {quot[gdc_pkg::INDEX_W-2:0], ge};

  assign push = (state == F_PUSH) && !full;

  always_comb begin
    job.center_index  = idx;
    job.center_column = rem;
    job.center_row    = quot;
    job.radius        = radius;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept && (req.diameter != '0)) begin
            state <= F_DIV;
            count <= '0;
          end
        end
        F_DIV: begin
          count <= count + 1'b1;
          if (count == DIV_COUNT_W'(gdc_pkg::INDEX_W - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx    <= req.center_index;
      quot   <= req.center_index;
      rem    <= '0;
      radius <= gdc_pkg::RADIUS_W'(dia_clamped >> 1);
    end else if (state == F_DIV) begin
      quot <= quot_next;
      rem  <= rem_next;
    end
  end

endmodule

/* rtl/gdc_queue.sv */
// gdc_queue: short job queue between the divider front and the offset walker.
// Depends on gdc_pkg.
module gdc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gdc_pkg::job_t push_job,
  input  logic          pop,
  output gdc_pkg::job_t pop_job,
  output logic          full,
  output logic          empty
);

  localparam int unsigned PTR_W   = (gdc_pkg::QUEUE_DEPTH > 1) ? $clog2(gdc_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned COUNT_W = $clog2(gdc_pkg::QUEUE_DEPTH + 1);

  gdc_pkg::job_t          entries [gdc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [COUNT_W-1:0]     fill;

  logic                   do_push;
  logic                   do_pop;

  assign full    = (fill == COUNT_W'(gdc_pkg::QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(gdc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(gdc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

/* rtl/gdc_back.sv */
// gdc_back: walks the distance-ordered offset table for one job, keeps the latest hit
// back so the final one can be flagged, and drives the result register. Depends on gdc_pkg, gdc_intf.
module gdc_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [gdc_pkg::GRID_SIZE_W-1:0]    cols,
  input  logic [gdc_pkg::GRID_SIZE_W-1:0]    rows,
  input  logic                               empty,
  input  gdc_pkg::job_t                      job,
  output logic                               pop,
  gdc_rsp_if.source                          rsp
);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_WALK = 2'b10
  } back_state_t;

  back_state_t                         state;
  logic [gdc_pkg::INDEX_W-1:0]         idx;
  logic [gdc_pkg::COORD_W-1:0]         cx;
  logic [gdc_pkg::INDEX_W-1:0]         cz;
  logic [gdc_pkg::DIST_W-1:0]          r2;
  logic [gdc_pkg::STEP_W-1:0]          step;
  logic [gdc_pkg::INDEX_W-1:0]         held_cell;
  logic [gdc_pkg::DIST_W-1:0]          held_distance;
  logic                                held_valid;
  logic                                out_valid;
  logic [gdc_pkg::INDEX_W-1:0]         out_cell;
  logic [gdc_pkg::DIST_W-1:0]          out_distance;
  logic                                out_last;

  gdc_pkg::offset_t                    ofs;
  logic                                walk_end;
  logic signed [9:0]                   x_pos;
  logic signed [17:0]                  z_pos;
  logic signed [18:0]                  cell_sum;
  logic                                hit;
  logic                                out_free;
  logic                                load_out;
  logic                                load_last;
  logic                                take_cand;
  logic                                advance;
  logic                                finish;

  assign ofs      = gdc_pkg::offset_entry(step);
  assign walk_end = (ofs.dist_sq > r2);

  assign x_pos    = $signed({2'b00, cx}) + 10'(ofs.dx);
  assign z_pos    = $signed({2'b00, cz}) + 18'(ofs.dz);
  assign cell_sum = $signed({3'b000, idx}) + 19'(ofs.dz) * $signed({10'b0, cols})
                  + 19'(ofs.dx);
  assign hit      = !x_pos[9] && (x_pos < $signed({1'b0, cols}))
                 && !z_pos[17] && (z_pos < $signed({9'b0, rows}));

  assign out_free = !out_valid || rsp.ready;
  assign pop      = (state == B_IDLE) && !empty;

  assign rsp.valid       = out_valid;
  assign rsp.cell_index  = out_cell;
  assign rsp.distance_sq = out_distance;
  assign rsp.last_flag   = out_last;

  always_comb begin
    load_out  = 1'b0;
    load_last = 1'b0;
    take_cand = 1'b0;
    advance   = 1'b0;
    finish    = 1'b0;
    if (state == B_WALK) begin
      if (walk_end) begin
        if (!held_valid) begin
          finish = 1'b1;
        end else if (out_free) begin
          load_out  = 1'b1;
          load_last = 1'b1;
          finish    = 1'b1;
        end
      end else if (hit) begin
        if (!held_valid || out_free) begin
          take_cand = 1'b1;
          advance   = 1'b1;
          load_out  = held_valid;
        end
      end else begin
        advance = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      step       <= '0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (pop) begin
            state <= B_WALK;
            step  <= '0;
          end
        end
        B_WALK: begin
          if (finish) begin
            state <= B_IDLE;
          end
          if (advance) begin
            step <= step + 1'b1;
          end
        end
        default: state <= B_IDLE;
      endcase
      if (finish) begin
        held_valid <= 1'b0;
      end else if (take_cand) begin
        held_valid <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      idx <= job.center_index;
      cx  <= job.center_column;
      cz  <= job.center_row;
      r2  <= gdc_pkg::DIST_W'(job.radius) * gdc_pkg::DIST_W'(job.radius);
    end
    if (take_cand) begin
      held_cell     <= cell_sum[gdc_pkg::INDEX_W-1:0];
      held_distance <= ofs.dist_sq;
    end
    if (load_out) begin
      out_cell     <= held_cell;
      out_distance <= held_distance;
      out_last     <= load_last;
    end
  end

endmodule

/* rtl/grid_disc_cells_by_distance_unit.sv */
// grid_disc_cells_by_distance_unit: lists grid cells within radius of a centre, nearest first.
// Front: accept, bit-serial divide, then push into the queue, which waits while the queue is full;
// the front takes no new request until its job is pushed. Back: pop, then one table offset
// per cycle unless a hit waits for the result register; it pops the next job only when the walk ends.
// The front can divide a new request while the back walks an earlier job. Reset is synchronous: queue
// and result register empty, grid size back to 16 by 16; no memory clearing pass.
module grid_disc_cells_by_distance_unit (
  input  logic     clk,
  input  logic     rst,
  gdc_req_if.sink  req,
  gdc_rsp_if.source rsp,
  gdc_cfg_if.sink  cfg
);

  logic [gdc_pkg::GRID_SIZE_W-1:0] grid_columns;
  logic [gdc_pkg::GRID_SIZE_W-1:0] grid_rows;
  logic [gdc_pkg::GRID_SIZE_W-1:0] cols;
  logic [gdc_pkg::GRID_SIZE_W-1:0] rows;

  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  gdc_pkg::job_t push_job;
  gdc_pkg::job_t pop_job;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= gdc_pkg::GRID_SIZE_RESET;
      grid_rows    <= gdc_pkg::GRID_SIZE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == gdc_pkg::REG_GRID_COLUMNS) begin
        grid_columns <= cfg.data;
      end else if (cfg.index == gdc_pkg::REG_GRID_ROWS) begin
        grid_rows <= cfg.data;
      end
    end
  end

  assign cols = gdc_pkg::clamp_size(grid_columns, gdc_pkg::MAX_COLUMNS);
  assign rows = gdc_pkg::clamp_size(grid_rows, gdc_pkg::MAX_ROWS);

  gdc_front u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cols (cols),
    .full (full),
    .push (push),
    .job  (push_job)
  );

  gdc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (full),
    .empty    (empty)
  );

  gdc_back u_back (
    .clk   (clk),
    .rst   (rst),
    .cols  (cols),
    .rows  (rows),
    .empty (empty),
    .job   (pop_job),
    .pop   (pop),
    .rsp   (rsp)
  );

endmodule

/* dv/grid_disc_cells_by_distance_unit_tb.sv */
// grid_disc_cells_by_distance_unit_tb: self-checking bench for the grid disc cell lister.
// Drives requests and register writes, predicts the ordered cell list, checks every result.
// Depends on gdc_pkg, the gdc channel interfaces and grid_disc_cells_by_distance_unit.
module grid_disc_cells_by_distance_unit_tb;
  import gdc_pkg::*;

  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES   = 250;
  localparam int unsigned IDLE_LIMIT      = 4000;
  localparam int unsigned REPORT_LIMIT    = 100;
  localparam cfg_index_t  REG_UNMAPPED    = 8'hFF;

  typedef enum logic [1:0] {
    CHECK_PREDICTED,
    CHECK_NO_CELLS,
    CHECK_CENTRE_ONLY
  } check_kind_t;

  typedef struct packed {
    logic [INDEX_W-1:0]    center;
    logic [DIAMETER_W-1:0] diameter;
    check_kind_t           kind;
  } stim_row_t;

  typedef struct packed {
    logic [INDEX_W-1:0] cell_idx;
    logic [DIST_W-1:0]  dist_sq;
    logic               last;
  } disc_cell_t;

  // directed requests on the 16 by 16 grid after reset
  localparam stim_row_t DIRECTED[25] = '{
    '{16'd0,     4'd0,  CHECK_NO_CELLS},
    '{16'd0,     4'd1,  CHECK_CENTRE_ONLY},
    '{16'd255,   4'd1,  CHECK_CENTRE_ONLY},
    '{16'd136,   4'd1,  CHECK_CENTRE_ONLY},
    '{16'd65535, 4'd0,  CHECK_NO_CELLS},
    '{16'd65535, 4'd9,  CHECK_NO_CELLS},
    '{16'd65535, 4'd1,  CHECK_NO_CELLS},
    '{16'd32768, 4'd5,  CHECK_NO_CELLS},
    '{16'd136,   4'd2,  CHECK_PREDICTED},
    '{16'd136,   4'd3,  CHECK_PREDICTED},
    '{16'd136,   4'd4,  CHECK_PREDICTED},
    '{16'd136,   4'd5,  CHECK_PREDICTED},
    '{16'd136,   4'd6,  CHECK_PREDICTED},
    '{16'd136,   4'd7,  CHECK_PREDICTED},
    '{16'd136,   4'd8,  CHECK_PREDICTED},
    '{16'd136,   4'd9,  CHECK_PREDICTED},
    '{16'd0,     4'd9,  CHECK_PREDICTED},
    '{16'd255,   4'd9,  CHECK_PREDICTED},
    '{16'd15,    4'd9,  CHECK_PREDICTED},
    '{16'd240,   4'd9,  CHECK_PREDICTED},
    '{16'd17,    4'd15, CHECK_PREDICTED},
    '{16'd7,     4'd10, CHECK_PREDICTED},
    '{16'd200,   4'd12, CHECK_PREDICTED},
    '{16'd271,   4'd5,  CHECK_PREDICTED},
    '{16'd300,   4'd3,  CHECK_PREDICTED}
  };

  logic clk;
  logic rst;

  gdc_req_if req_ch();
  gdc_rsp_if rsp_ch();
  gdc_cfg_if cfg_ch();

  grid_disc_cells_by_distance_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  logic [GRID_SIZE_W-1:0] grid_columns_q;
  logic [GRID_SIZE_W-1:0] grid_rows_q;
  disc_cell_t             pending_cells[$];
  int unsigned            mismatches;
  bit                     steady;
  bit                     hold_off_pending;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned effective_size(input logic [GRID_SIZE_W-1:0] v,
                                                 input int unsigned top);
    int unsigned res;
    if (v == '0) begin
      res = 1;
    end else if (32'(v) > top) begin
      res = top;
    end else begin
      res = 32'(v);
    end
    return res;
  endfunction

  // cells inside the disc, nearest first, ties by ascending index
  function automatic void predict_disc(input logic [INDEX_W-1:0] center,
                                       input logic [DIAMETER_W-1:0] dia_in);
    int unsigned cols, rows, dia, cx, cz, r, xlo, xhi, zlo, zhi, dx, dz;
    disc_cell_t  found[$];
    disc_cell_t  c;
    if (dia_in == '0) return;
    cols = effective_size(grid_columns_q, 32'(MAX_COLUMNS));
    rows = effective_size(grid_rows_q, 32'(MAX_ROWS));
    dia  = (dia_in > MAX_DIAMETER) ? 32'(MAX_DIAMETER) : 32'(dia_in);
    cx   = 32'(center) % cols;
    cz   = 32'(center) / cols;
    r    = dia / 2;
    xlo  = (cx > r) ? cx - r : 0;
    xhi  = (cx + r < cols - 1) ? cx + r : cols - 1;
    zlo  = (cz > r) ? cz - r : 0;
    zhi  = (cz + r < rows - 1) ? cz + r : rows - 1;
    for (int unsigned d2 = 0; d2 <= r * r; d2++) begin
      for (int unsigned z = zlo; z <= zhi; z++) begin
        for (int unsigned x = xlo; x <= xhi; x++) begin
          dx = (x > cx) ? x - cx : cx - x;
          dz = (z > cz) ? z - cz : cz - z;
          if (dx * dx + dz * dz == d2) begin
            c.cell_idx = INDEX_W'(z * cols + x);
            c.dist_sq  = DIST_W'(d2);
            c.last     = 1'b0;
            found.push_back(c);
          end
        end
      end
    end
    foreach (found[i]) begin
      c      = found[i];
      c.last = (i == found.size() - 1);
      pending_cells.push_back(c);
    end
  endfunction

  task automatic send_request(input logic [INDEX_W-1:0] center,
                              input logic [DIAMETER_W-1:0] dia,
                              input check_kind_t kind);
    int unsigned roll, gap;
    disc_cell_t  c;
    req_ch.valid        <= 1'b1;
    req_ch.center_index <= center;
    req_ch.diameter     <= dia;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    case (kind)
      CHECK_PREDICTED: begin
        predict_disc(center, dia);
      end
      CHECK_CENTRE_ONLY: begin
        c.cell_idx = center;
        c.dist_sq  = '0;
        c.last     = 1'b1;
        pending_cells.push_back(c);
      end
      default: begin
      end
    endcase
    if (!steady) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        gap = 0;
      end else if (roll < 92) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(15, 60);
      end
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_random(input int unsigned count);
    int unsigned           cols, rows, roll;
    logic [INDEX_W-1:0]    center;
    logic [DIAMETER_W-1:0] dia;
    cols = effective_size(grid_columns_q, 32'(MAX_COLUMNS));
    rows = effective_size(grid_rows_q, 32'(MAX_ROWS));
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        center = INDEX_W'($urandom());
      end else begin
        center = INDEX_W'($urandom_range(0, rows - 1) * cols + $urandom_range(0, cols - 1));
      end
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        dia = DIAMETER_W'($urandom_range(1, MAX_DIAMETER));
      end else begin
        dia = DIAMETER_W'($urandom_range(0, 15));
      end
      send_request(center, dia, CHECK_PREDICTED);
    end
  endtask

  // wait for every result, then for requests that give none to drain
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [GRID_SIZE_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_GRID_COLUMNS: grid_columns_q = value;
      REG_GRID_ROWS:    grid_rows_q    = value;
      default: begin
      end
    endcase
  endtask

  task automatic reconfigure(input logic [GRID_SIZE_W-1:0] cols,
                             input logic [GRID_SIZE_W-1:0] rows,
                             input bit poke_unmapped);
    settle();
    write_reg(REG_GRID_COLUMNS, cols);
    write_reg(REG_GRID_ROWS, rows);
    if (poke_unmapped) write_reg(REG_UNMAPPED, GRID_SIZE_W'($urandom()));
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.center_index <= '0;
    req_ch.diameter     <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= '0;
    cfg_ch.data         <= '0;
    grid_columns_q   = GRID_SIZE_RESET;
    grid_rows_q      = GRID_SIZE_RESET;
    mismatches       = 0;
    steady           = 1'b0;
    hold_off_pending = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) send_request(DIRECTED[i].center, DIRECTED[i].diameter,
                                       DIRECTED[i].kind);
    send_random(12);
    reconfigure(9'd1, 9'd1, 1'b0);
    send_random(8);
    reconfigure(9'd0, 9'd0, 1'b0);
    send_random(6);
    reconfigure(9'd511, 9'd511, 1'b0);
    send_random(12);
    reconfigure(9'd256, 9'd1, 1'b0);
    send_random(8);
    reconfigure(9'd1, 9'd256, 1'b0);
    send_random(8);
    reconfigure(9'd5, 9'd7, 1'b1);
    send_random(10);

    // long hold-off at the result side while requests keep coming
    reconfigure(GRID_SIZE_W'($urandom_range(1, 40)), GRID_SIZE_W'($urandom_range(1, 40)), 1'b0);
    steady           = 1'b1;
    hold_off_pending = 1'b1;
    send_random(20);
    steady = 1'b0;

    reconfigure(GRID_SIZE_W'($urandom_range(0, 511)), GRID_SIZE_W'($urandom_range(0, 511)),
                1'b0);
    send_random(12);
    settle();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : drive_result_ready
    int unsigned low_left, steady_left, roll;
    rsp_ch.ready <= 1'b0;
    low_left    = 0;
    steady_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        low_left         = HOLD_OFF_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else if (low_left > 0) begin
        low_left--;
        rsp_ch.ready <= 1'b0;
      end else if (steady || steady_left > 0) begin
        if (steady_left > 0) steady_left--;
        rsp_ch.ready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          steady_left = $urandom_range(40, 150);
          rsp_ch.ready <= 1'b1;
        end else if (roll < 70) begin
          rsp_ch.ready <= 1'b1;
        end else if (roll < 96) begin
          low_left = $urandom_range(0, 3);
          rsp_ch.ready <= 1'b0;
        end else begin
          low_left = $urandom_range(10, 60);
          rsp_ch.ready <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    disc_cell_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: unexpected transaction, got cell %0d dist %0d last %0d", $time,
                   rsp_ch.cell_index, rsp_ch.distance_sq, rsp_ch.last_flag);
        end
      end else begin
        want = pending_cells.pop_front();
        if (rsp_ch.cell_index !== want.cell_idx || rsp_ch.distance_sq !== want.dist_sq ||
            rsp_ch.last_flag !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: expected cell %0d dist %0d last %0d, got cell %0d dist %0d last %0d",
                     $time, want.cell_idx, want.dist_sq, want.last,
                     rsp_ch.cell_index, rsp_ch.distance_sq, rsp_ch.last_flag);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAIL");
    $finish;
  end

endmodule
